@@ rtl/core/imr_pkg.sv @@
// shared types and constants for the ipv4 multicast replicator
// no dependencies; used by ipv4_multicast_replicator and the testbench
package imr_pkg;

  localparam int NUM_PORTS     = 16;
  localparam int BURST_SIZE    = 32;
  localparam int TABLE_ENTRIES = 1024;

  localparam int IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int CNT_W   = $clog2(BURST_SIZE + 1);
  localparam int ENTRY_W = 1 + 32 + 16;

  localparam logic [47:0] MCAST_MAC_BASE = 48'h01005e000000;
  localparam logic [31:0] DRAIN_RESET    = 32'd200000;

  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_FWD  = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  localparam logic [2:0] K_COPY  = 3'd0;
  localparam logic [2:0] K_FLUSH = 3'd1;
  localparam logic [2:0] K_DROP  = 3'd2;
  localparam logic [2:0] K_ADD   = 3'd3;
  localparam logic [2:0] K_FULL  = 3'd4;

  localparam logic CFG_ENABLED = 1'b0;
  localparam logic CFG_DRAIN   = 1'b1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] group_address;
    logic [15:0] group_ports;
    logic [63:0] now_time;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  out_port;
    logic [47:0] dest_mac;
    logic [5:0]  flush_count;
    logic        last;
  } out_word_t;

  // fold the group address into a table index
  function automatic logic [IDX_W-1:0] group_hash(input logic [31:0] addr);
    logic [IDX_W-1:0] h;
    logic [31:0]      a;
    h = '0;
    a = addr;
    for (int i = 0; i < (32 + IDX_W - 1) / IDX_W; i++) begin
      h = h ^ a[IDX_W-1:0];
      a = a >> IDX_W;
    end
    return h;
  endfunction

endpackage

@@ rtl/core/imr_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module imr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/ipv4_multicast_replicator.sv @@
// ipv4 multicast replicator top level: group table, per-port burst counters
// depends on imr_pkg and imr_ram
//
// After reset the block clears all TABLE_ENTRIES (1024) entries of the group
// table and holds in_stall high; configuration writes are taken throughout.
// The group table is one ram of {valid, key, mask} entries searched by linear
// probing from a hash of the address, each probe a read and then a compare.
// Every item is accepted in the idle state. A non-multicast forward then
// emits its drop word. An add or any other forward probes the table; an add,
// or a forward that is dropped, then emits one word. A forward that hits walks
// the ports in order from port 0 up to its highest destination, with a flush
// word after each port whose burst count reaches BURST_SIZE. A tick adds the
// drain interval to the last drain time and, when due, scans the ports from
// port 0 and flushes each pending count. Each result word goes through the
// output register and is held there while out_stall is high.
module ipv4_multicast_replicator (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  imr_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output imr_pkg::out_word_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_RD      = 4'd2;
  localparam logic [3:0] S_CHK     = 4'd3;
  localparam logic [3:0] S_EMIT1   = 4'd4;
  localparam logic [3:0] S_PORTS   = 4'd5;
  localparam logic [3:0] S_FLUSHP  = 4'd6;
  localparam logic [3:0] S_TADD    = 4'd7;
  localparam logic [3:0] S_TCMP    = 4'd8;
  localparam logic [3:0] S_TSCAN   = 4'd9;

  logic [3:0]                     state;
  imr_pkg::in_word_t              item;
  logic [imr_pkg::IDX_W-1:0]      idx;
  logic [imr_pkg::IDX_W-1:0]      probes;
  logic [15:0]                    hit_mask;
  logic [2:0]                     one_kind;
  logic [3:0]                     port;
  logic [imr_pkg::CNT_W-1:0]      pend [imr_pkg::NUM_PORTS];
  logic [imr_pkg::CNT_W-1:0]      flush_cnt;
  logic [15:0]                    enabled;
  logic [31:0]                    interval;
  logic [63:0]                    last_drain;
  logic [64:0]                    due;

  logic                           ram_we;
  logic [imr_pkg::ENTRY_W-1:0]    ram_wdata;
  logic [imr_pkg::ENTRY_W-1:0]    ram_rdata;
  logic                           ent_valid;
  logic [31:0]                    ent_key;
  logic [15:0]                    ent_mask;
  logic                           can_emit;
  logic                           emit_now;
  logic [16:0]                    above;
  logic                           hit_higher;
  logic [15:0]                    nz;
  logic                           nz_higher;
  logic [15:0]                    port_range;
  logic [imr_pkg::CNT_W-1:0]      pend_inc;
  logic [47:0]                    mac;

  imr_ram #(
    .WIDTH(imr_pkg::ENTRY_W),
    .DEPTH(imr_pkg::TABLE_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(idx),
    .wdata(ram_wdata),
    .raddr(idx),
    .rdata(ram_rdata)
  );

  assign ent_valid = ram_rdata[imr_pkg::ENTRY_W-1];
  assign ent_key   = ram_rdata[47:16];
  assign ent_mask  = ram_rdata[15:0];

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign can_emit  = !out_valid || !out_stall;

  // a word is loaded into the output register this cycle
  assign emit_now = can_emit && ((state == S_EMIT1) || (state == S_FLUSHP) ||
                                 (state == S_PORTS && hit_mask[port]) ||
                                 (state == S_TSCAN && nz[port]));

  // bits strictly above the current port
  assign above      = ~((17'd2 << port) - 17'd1);
  assign hit_higher = |({1'b0, hit_mask} & above);
  assign port_range = 16'((17'd1 << imr_pkg::NUM_PORTS) - 17'd1);
  assign pend_inc   = pend[port] + 1'b1;
  assign mac        = imr_pkg::MCAST_MAC_BASE | {25'd0, item.group_address[22:0]};

  always_comb begin
    for (int p = 0; p < imr_pkg::NUM_PORTS; p++) begin
      nz[p] = (pend[p] != '0);
    end
  end
  assign nz_higher = |({1'b0, nz} & above);

  // table write: clearing pass, or an add that hits or finds a free entry
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = '0;
    if (state == S_CLEAR) begin
      ram_we = 1'b1;
    end else if (state == S_CHK && item.opcode == imr_pkg::OP_ADD &&
                 (!ent_valid || ent_key == item.group_address)) begin
      ram_we    = 1'b1;
      ram_wdata = {1'b1, item.group_address, item.group_ports};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      idx        <= '0;
      out_valid  <= 1'b0;
      enabled    <= '0;
      interval   <= imr_pkg::DRAIN_RESET;
      last_drain <= '0;
      for (int p = 0; p < imr_pkg::NUM_PORTS; p++) begin
        pend[p] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          imr_pkg::CFG_ENABLED: enabled  <= cfg_data[15:0];
          imr_pkg::CFG_DRAIN:   interval <= cfg_data;
          default: ;
        endcase
      end

      if (emit_now) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          idx <= idx + 1'b1;
          if (idx == imr_pkg::IDX_W'(imr_pkg::TABLE_ENTRIES - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_valid) begin
            item   <= in_data;
            idx    <= imr_pkg::group_hash(in_data.group_address);
            probes <= '0;
            case (in_data.opcode)
              imr_pkg::OP_ADD: state <= S_RD;
              imr_pkg::OP_FWD: begin
                if (in_data.group_address[31:28] == 4'he) begin
                  state <= S_RD;
                end else begin
                  one_kind <= imr_pkg::K_DROP;
                  state    <= S_EMIT1;
                end
              end
              imr_pkg::OP_TICK: state <= S_TADD;
              default: ;
            endcase
          end
        end

        S_RD: begin
          state <= S_CHK;
        end

        S_CHK: begin
          if (ent_valid && ent_key == item.group_address) begin
            if (item.opcode == imr_pkg::OP_ADD) begin
              one_kind <= imr_pkg::K_ADD;
              state    <= S_EMIT1;
            end else if ((ent_mask & enabled & port_range) == '0) begin
              one_kind <= imr_pkg::K_DROP;
              state    <= S_EMIT1;
            end else begin
              hit_mask <= ent_mask & enabled & port_range;
              port     <= '0;
              state    <= S_PORTS;
            end
          end else if (!ent_valid) begin
            one_kind <= (item.opcode == imr_pkg::OP_ADD) ? imr_pkg::K_ADD : imr_pkg::K_DROP;
            state    <= S_EMIT1;
          end else if (probes == imr_pkg::IDX_W'(imr_pkg::TABLE_ENTRIES - 1)) begin
            one_kind <= (item.opcode == imr_pkg::OP_ADD) ? imr_pkg::K_FULL : imr_pkg::K_DROP;
            state    <= S_EMIT1;
          end else begin
            idx    <= idx + 1'b1;
            probes <= probes + 1'b1;
            state  <= S_RD;
          end
        end

        S_EMIT1: begin
          if (can_emit) begin
            out_data  <= '{kind: one_kind, out_port: '0, dest_mac: '0,
                           flush_count: '0, last: 1'b1};
            state     <= S_IDLE;
          end
        end

        S_PORTS: begin
          if (!hit_mask[port]) begin
            port <= port + 1'b1;
          end else if (can_emit) begin
            if (pend_inc >= imr_pkg::CNT_W'(imr_pkg::BURST_SIZE)) begin
              out_data  <= '{kind: imr_pkg::K_COPY, out_port: port, dest_mac: mac,
                             flush_count: '0, last: 1'b0};
              pend[port] <= '0;
              flush_cnt  <= pend_inc;
              state      <= S_FLUSHP;
            end else begin
              out_data  <= '{kind: imr_pkg::K_COPY, out_port: port, dest_mac: mac,
                             flush_count: '0, last: !hit_higher};
              pend[port] <= pend_inc;
              if (hit_higher) begin
                port <= port + 1'b1;
              end else begin
                state <= S_IDLE;
              end
            end
          end
        end

        S_FLUSHP: begin
          if (can_emit) begin
            out_data  <= '{kind: imr_pkg::K_FLUSH, out_port: port, dest_mac: '0,
                           flush_count: 6'(flush_cnt), last: !hit_higher};
            if (hit_higher) begin
              port  <= port + 1'b1;
              state <= S_PORTS;
            end else begin
              state <= S_IDLE;
            end
          end
        end

        S_TADD: begin
          due   <= {1'b0, last_drain} + {33'd0, interval};
          state <= S_TCMP;
        end

        S_TCMP: begin
          if (!due[64] && item.now_time >= due[63:0]) begin
            last_drain <= item.now_time;
            port       <= '0;
            state      <= (nz == '0) ? S_IDLE : S_TSCAN;
          end else begin
            state <= S_IDLE;
          end
        end

        S_TSCAN: begin
          if (!nz[port]) begin
            port <= port + 1'b1;
          end else if (can_emit) begin
            out_data   <= '{kind: imr_pkg::K_FLUSH, out_port: port, dest_mac: '0,
                            flush_count: 6'(pend[port]), last: !nz_higher};
            pend[port] <= '0;
            if (nz_higher) begin
              port <= port + 1'b1;
            end else begin
              state <= S_IDLE;
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ dv/tb_ipv4_multicast_replicator.sv @@
// self-checking testbench for ipv4_multicast_replicator
// depends on imr_pkg and the rtl; a local group table model predicts every output word
`timescale 1ns / 100ps

module tb_ipv4_multicast_replicator;

  // opcode with no meaning, must be ignored
  localparam logic [1:0] OP_SPARE = 2'd3;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  imr_pkg::in_word_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b1;
  imr_pkg::out_word_t out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_index = imr_pkg::CFG_ENABLED;
  logic [31:0]        cfg_data = '0;

  ipv4_multicast_replicator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // model state
  logic [15:0] group_mask_of [logic [31:0]];
  logic [6:0]  port_backlog [imr_pkg::NUM_PORTS];
  logic [63:0] drained_at = '0;
  logic [15:0] port_enable = '0;
  logic [31:0] drain_gap = imr_pkg::DRAIN_RESET;

  imr_pkg::in_word_t  send_q [$];
  imr_pkg::out_word_t words_due [$];
  int          errors = 0;
  int unsigned cyc = 0;
  int unsigned in_gap = 0;
  int unsigned out_wait = 0;

  always @(posedge clk) cyc <= cyc + 1;

  // long receiver hold-off so the block backs up into its input
  logic long_hold;
  always @(posedge clk) long_hold <= (cyc >= 3000 && cyc < 3500);

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic push_word(input logic [2:0] k, input logic [3:0] p, input logic [47:0] mac,
                           input logic [5:0] cnt);
    imr_pkg::out_word_t w;
    w = '{kind: k, out_port: p, dest_mac: mac, flush_count: cnt, last: 1'b0};
    words_due.push_back(w);
  endtask

  // expected words for one accepted input word
  task automatic replicate(input imr_pkg::in_word_t w);
    int          first_len;
    logic [15:0] fanout;
    logic [64:0] due;
    first_len = words_due.size();
    fanout = '0;
    case (w.opcode)
      imr_pkg::OP_ADD: begin
        if (group_mask_of.exists(w.group_address) ||
            group_mask_of.num() < imr_pkg::TABLE_ENTRIES) begin
          group_mask_of[w.group_address] = w.group_ports;
          push_word(imr_pkg::K_ADD, 0, 0, 0);
        end else begin
          push_word(imr_pkg::K_FULL, 0, 0, 0);
        end
      end
      imr_pkg::OP_FWD: begin
        if (w.group_address[31:28] == 4'he && group_mask_of.exists(w.group_address))
          fanout = group_mask_of[w.group_address] & port_enable;
        if (fanout == 0) begin
          push_word(imr_pkg::K_DROP, 0, 0, 0);
        end else begin
          for (int p = 0; p < imr_pkg::NUM_PORTS; p++) begin
            if (fanout[p]) begin
              push_word(imr_pkg::K_COPY, p,
                        imr_pkg::MCAST_MAC_BASE | {25'd0, w.group_address[22:0]}, 0);
              port_backlog[p]++;
              if (port_backlog[p] >= imr_pkg::BURST_SIZE) begin
                push_word(imr_pkg::K_FLUSH, p, 0, port_backlog[p][5:0]);
                port_backlog[p] = 0;
              end
            end
          end
        end
      end
      imr_pkg::OP_TICK: begin
        due = {1'b0, drained_at} + {33'd0, drain_gap};
        // no wrap: an overflowing deadline is never due
        if (!due[64] && w.now_time >= due[63:0]) begin
          for (int p = 0; p < imr_pkg::NUM_PORTS; p++) begin
            if (port_backlog[p] != 0) begin
              push_word(imr_pkg::K_FLUSH, p, 0, port_backlog[p][5:0]);
              port_backlog[p] = 0;
            end
          end
          drained_at = w.now_time;
        end
      end
      default: ;
    endcase
    if (words_due.size() > first_len) words_due[$].last = 1'b1;
  endtask

  function automatic int unsigned draw_wait(input logic calm);
    return calm ? 0 : $urandom_range(0, 11);
  endfunction

  // input driver
  always @(posedge clk) begin
    logic take;
    take = in_valid && !in_stall;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (take) replicate(in_data);
      if (!in_valid || take) begin
        if (in_gap != 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (send_q.size() != 0) begin
          in_data <= send_q.pop_front();
          in_valid <= 1'b1;
          in_gap <= draw_wait(cyc[9]);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor
  always @(posedge clk) begin
    imr_pkg::out_word_t want;
    if (rst) begin
      out_stall <= 1'b1;
    end else begin
      if (out_valid && !out_stall) begin
        if (words_due.size() == 0) begin
          report("unexpected word", out_data, 0);
        end else begin
          want = words_due.pop_front();
          if (out_data.kind != want.kind) report("kind", out_data.kind, want.kind);
          if (out_data.out_port != want.out_port)
            report("out_port", out_data.out_port, want.out_port);
          if (out_data.dest_mac != want.dest_mac)
            report("dest_mac", out_data.dest_mac, want.dest_mac);
          if (out_data.flush_count != want.flush_count)
            report("flush_count", out_data.flush_count, want.flush_count);
          if (out_data.last != want.last) report("last", out_data.last, want.last);
        end
        out_wait <= draw_wait(cyc[10]);
        out_stall <= long_hold;
      end else if (out_wait != 0) begin
        out_wait <= out_wait - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= long_hold;
      end
    end
  end

  task automatic send(input logic [1:0] op, input logic [31:0] addr, input logic [15:0] ports,
                      input logic [63:0] now);
    imr_pkg::in_word_t w;
    w = '{opcode: op, group_address: addr, group_ports: ports, now_time: now};
    send_q.push_back(w);
  endtask

  task automatic wait_idle();
    while (send_q.size() != 0 || in_valid || words_due.size() != 0) @(posedge clk);
    // a tick may still be checking its deadline with nothing to report
    repeat (64) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == imr_pkg::CFG_ENABLED) port_enable = val[15:0];
    else drain_gap = val;
  endtask

  logic [31:0] group_pool [24];
  logic [63:0] clock_now = 64'd100;

  task automatic random_items(input int count);
    logic [31:0] a;
    int unsigned r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      a = group_pool[$urandom_range(0, 23)];
      if (r < 15) begin
        send(imr_pkg::OP_ADD, a, ($urandom_range(0, 7) == 0) ? 16'h0 : 16'($urandom),
             {$urandom, $urandom});
      end else if (r < 80) begin
        if ($urandom_range(0, 4) == 0) a = $urandom;
        send(imr_pkg::OP_FWD, a, 16'($urandom), {$urandom, $urandom});
      end else if (r < 95) begin
        clock_now += $urandom_range(0, 3000);
        send(imr_pkg::OP_TICK, $urandom, 16'($urandom), clock_now);
      end else begin
        send(OP_SPARE, $urandom, 16'($urandom), {$urandom, $urandom});
      end
    end
  endtask

  initial begin
    for (int p = 0; p < imr_pkg::NUM_PORTS; p++) port_backlog[p] = 0;
    for (int i = 0; i < 24; i++) group_pool[i] = {4'he, 28'($urandom)};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // writes are taken while the table clears
    cfg_write(imr_pkg::CFG_ENABLED, 32'hffff);
    cfg_write(imr_pkg::CFG_DRAIN, 32'd0);

    send(imr_pkg::OP_ADD, 32'he000_0001, 16'hffff, 64'd0);
    send(imr_pkg::OP_ADD, 32'hefff_ffff, 16'h0001, 64'd0);
    send(imr_pkg::OP_ADD, 32'he812_3456, 16'h0000, 64'd0);    // empty mask
    send(imr_pkg::OP_FWD, 32'he000_0001, 16'h0, 64'd0);
    send(imr_pkg::OP_ADD, 32'he000_0001, 16'h8001, 64'd0);    // replace mask
    send(imr_pkg::OP_FWD, 32'he000_0001, 16'hffff, 64'hffff_ffff_ffff_ffff);
    send(imr_pkg::OP_FWD, 32'hefff_ffff, 16'h0, 64'd0);
    send(imr_pkg::OP_FWD, 32'he812_3456, 16'h0, 64'd0);
    send(imr_pkg::OP_FWD, 32'h0000_0000, 16'h0, 64'd0);       // not multicast
    send(imr_pkg::OP_FWD, 32'hffff_ffff, 16'h0, 64'd0);
    send(imr_pkg::OP_FWD, 32'hdfff_ffff, 16'h0, 64'd0);
    send(imr_pkg::OP_FWD, 32'he000_0002, 16'h0, 64'd0);       // unknown group
    send(OP_SPARE, 32'hffff_ffff, 16'hffff, 64'hffff_ffff_ffff_ffff);
    send(imr_pkg::OP_TICK, 32'h0, 16'h0, 64'd0);              // due at once, flushes
    send(imr_pkg::OP_TICK, 32'h0, 16'h0, 64'd0);              // nothing pending
    wait_idle();

    cfg_write(imr_pkg::CFG_ENABLED, 32'h0);
    send(imr_pkg::OP_FWD, 32'he000_0001, 16'h0, 64'd0);
    send(imr_pkg::OP_TICK, 32'h0, 16'h0, 64'd1);
    wait_idle();

    cfg_write(imr_pkg::CFG_ENABLED, 32'hffff);
    cfg_write(imr_pkg::CFG_DRAIN, 32'd5000);
    random_items(110);
    wait_idle();
    cfg_write(imr_pkg::CFG_ENABLED, $urandom);
    cfg_write(imr_pkg::CFG_DRAIN, 32'd0);
    random_items(110);
    wait_idle();
    cfg_write(imr_pkg::CFG_ENABLED, 32'h8001);
    cfg_write(imr_pkg::CFG_DRAIN, 32'd200000);
    random_items(100);
    wait_idle();
    cfg_write(imr_pkg::CFG_ENABLED, 32'hffff);
    cfg_write(imr_pkg::CFG_DRAIN, 32'd1500);
    random_items(110);
    wait_idle();

    // deadline overflow: second tick is never due
    cfg_write(imr_pkg::CFG_DRAIN, 32'hffff_ffff);
    send(imr_pkg::OP_TICK, 32'h0, 16'h0, 64'hffff_ffff_ffff_ffff);
    send(imr_pkg::OP_TICK, 32'h0, 16'h0, 64'hffff_ffff_ffff_ffff);
    wait_idle();

    // a few more adds and forwards on fresh groups
    send(imr_pkg::OP_ADD, 32'hee00_0000, 16'hffff, 64'd0);
    send(imr_pkg::OP_ADD, 32'he100_0003, 16'h00f0, 64'd0);
    send(imr_pkg::OP_FWD, 32'he100_0003, 16'h0, 64'd0);
    send(imr_pkg::OP_FWD, 32'hee00_0000, 16'h0, 64'd0);
    wait_idle();

    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("tb_ipv4_multicast_replicator: clean");
    end else begin
      $display("tb_ipv4_multicast_replicator: errors");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("tb_ipv4_multicast_replicator: errors");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/imr_pkg.sv
rtl/core/imr_ram.sv
rtl/core/ipv4_multicast_replicator.sv
dv/tb_ipv4_multicast_replicator.sv
